FILE: rtl/lwrc_pkg.sv
package lwrc_pkg;

    localparam int NUM_ENTRIES = 8;
    localparam int KEY_WIDTH   = 32;
    localparam int AGE_WIDTH   = 32;
    localparam int IDX_W       = $clog2(NUM_ENTRIES);
    localparam int CNT_W       = $clog2(NUM_ENTRIES + 1);
    localparam int REG_INDEX_W = 3;
    localparam int VALUE_W     = 32;
    localparam int IN_TDATA_W  = 40;
    localparam int IN_TUSER_W  = 4;
    localparam int OUT_TDATA_W = 48;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    localparam logic [2:0] KIND_IMM    = 3'd0;
    localparam logic [2:0] KIND_GLOBAL = 3'd1;
    localparam logic [2:0] KIND_LOCAL  = 3'd2;
    localparam logic [2:0] KIND_REGVAR = 3'd3;

    localparam logic [1:0] EK_IMM    = 2'd0;
    localparam logic [1:0] EK_GLOBAL = 2'd1;
    localparam logic [1:0] EK_LOCAL  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BYPASS,
        ST_SCAN,
        ST_RESOLVE,
        ST_FL_READ,
        ST_FL_PUT
    } state_t;

    typedef struct packed {
        logic [1:0]           kind;
        logic [KEY_WIDTH-1:0] key;
    } mem_word_t;

    typedef struct packed {
        logic                   age_all;
        logic                   clr;
        logic [IDX_W-1:0]       clr_idx;
    } age_ctl_t;

    typedef struct packed {
        logic                   error;
        logic [1:0]             fill_kind;
        logic                   fill_valid;
        logic [VALUE_W-1:0]     spill_value;
        logic                   spill_kind;
        logic                   spill_valid;
        logic                   hit;
        logic [REG_INDEX_W-1:0] reg_index;
        logic                   reg_bank;
    } res_t;

    localparam int RES_W = $bits(res_t);

endpackage

FILE: rtl/lwrc_ram.sv
module lwrc_ram #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 3
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/lwrc_age.sv
module lwrc_age (
    input  logic                             clk,
    input  logic                             rst_n,
    input  lwrc_pkg::age_ctl_t               ctl,
    input  logic [lwrc_pkg::IDX_W-1:0]       rd_idx,
    output logic [lwrc_pkg::AGE_WIDTH-1:0]   rd_age
);

    import lwrc_pkg::*;

    localparam logic [AGE_WIDTH-1:0] AGE_MAX = '1;

    logic [AGE_WIDTH-1:0] age_reg  [NUM_ENTRIES];
    logic [AGE_WIDTH-1:0] age_next [NUM_ENTRIES];

    always_comb
    begin
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            age_next[i] = age_reg[i];
            if (ctl.clr && (ctl.clr_idx == IDX_W'(i)))
            begin
                age_next[i] = '0;
            end
            else if (ctl.age_all && (age_reg[i] != AGE_MAX))
            begin
                age_next[i] = age_reg[i] + AGE_WIDTH'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_ENTRIES; i++)
            begin
                age_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < NUM_ENTRIES; i++)
            begin
                age_reg[i] <= age_next[i];
            end
        end
    end

    assign rd_age = age_reg[rd_idx];

endmodule

FILE: rtl/lru_writeback_register_cache.sv
// Register cache of eight temporary registers keyed by operand kind and value.
// Input channel s_axis: tuser carries opcode and kind, tdata the key value,
// saved register number and is_def flag. Output channel m_axis: tdata carries
// one result item, tlast marks the final result of an input item.
// An allocate reads the entry memory one entry per cycle while tags are
// compared and the oldest entry is tracked; then the resolve state settles
// hit or replacement and, on a replacement, writes the new entry into the
// memory. A register-variable item goes straight to its result. A flush
// makes one memory read and one result per entry.
// One item is worked on at a time; a new item is taken once the previous one
// has put its last result into the output register, which may still wait.
// Reset clears all valid and dirty marks and all ages; no clearing pass runs
// and the block is ready to take an item as soon as reset is released.
// When the receiver stalls, the output register holds its item and the block
// waits before producing the next result.
module lru_writeback_register_cache (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // key_value[31:0], saved_reg_id[34:32], is_def[35]
    input  logic [lwrc_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    // opcode[0], kind[3:1]
    input  logic [lwrc_pkg::IN_TUSER_W-1:0]       s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // reg_bank[0], reg_index[3:1], hit[4], spill_valid[5], spill_kind[6],
    // spill_value[38:7], fill_valid[39], fill_kind[41:40], error[42]
    output logic [lwrc_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    output logic                                  m_axis_tlast
);

    import lwrc_pkg::*;

    state_t state_reg, state_next;

    logic [1:0]             kind_reg;
    logic [KEY_WIDTH-1:0]   key_reg;
    logic [2:0]             sreg_reg;
    logic                   def_reg;
    logic                   err_reg;

    logic [NUM_ENTRIES-1:0] valid_reg;
    logic [NUM_ENTRIES-1:0] dirty_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic                   hit_reg;
    logic [IDX_W-1:0]       hit_idx_reg;
    logic [IDX_W-1:0]       best_idx_reg;
    logic [AGE_WIDTH-1:0]   best_age_reg;
    mem_word_t              vic_reg;

    logic                   out_valid_reg;
    logic                   out_last_reg;
    res_t                   out_res_reg;

    logic                   in_fire;
    logic                   slot_free;
    logic                   out_load;
    logic                   out_last;
    res_t                   res;
    logic                   rd_en;
    logic [IDX_W-1:0]       rd_addr;
    logic                   wr_en;
    mem_word_t              wr_word;
    mem_word_t              rd_word;
    age_ctl_t               age_ctl;
    logic [IDX_W-1:0]       scan_idx;
    logic [IDX_W-1:0]       cur_idx;
    logic [AGE_WIDTH-1:0]   rd_age;
    logic                   scan_proc;
    logic                   scan_hit;
    logic                   victim_spill;
    logic                   flush_spill;

    logic                   in_op;
    logic [2:0]             in_kind;
    logic [VALUE_W-1:0]     in_key;

    assign in_op   = s_axis_tuser[0];
    assign in_kind = s_axis_tuser[3:1];
    assign in_key  = s_axis_tdata[VALUE_W-1:0];

    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign slot_free = !out_valid_reg || m_axis_tready;
    assign scan_idx  = IDX_W'(cnt_reg - CNT_W'(1));
    assign cur_idx   = cnt_reg[IDX_W-1:0];
    assign scan_proc = (state_reg == ST_SCAN) && (cnt_reg != '0);
    assign scan_hit  = valid_reg[scan_idx] && (rd_word.kind == kind_reg)
                       && (rd_word.key == key_reg);

    assign victim_spill = valid_reg[best_idx_reg] && dirty_reg[best_idx_reg]
                          && (vic_reg.kind != EK_IMM);
    assign flush_spill  = valid_reg[cur_idx] && dirty_reg[cur_idx]
                          && (rd_word.kind != EK_IMM);

    lwrc_ram #(
        .DATA_W ($bits(mem_word_t)),
        .ADDR_W (IDX_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (best_idx_reg),
        .wr_data (wr_word),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_word)
    );

    lwrc_age u_age (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (age_ctl),
        .rd_idx (scan_idx),
        .rd_age (rd_age)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_op == OP_FLUSH)
                    begin
                        state_next = ST_FL_READ;
                    end
                    else if (in_kind == KIND_REGVAR)
                    begin
                        state_next = ST_BYPASS;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_BYPASS:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (cnt_reg == CNT_W'(NUM_ENTRIES))
                begin
                    state_next = ST_RESOLVE;
                end
            end
            ST_RESOLVE:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FL_READ:
            begin
                state_next = ST_FL_PUT;
            end
            ST_FL_PUT:
            begin
                if (slot_free)
                begin
                    if (cnt_reg == CNT_W'(NUM_ENTRIES - 1))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_FL_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_axis_tready   = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = cur_idx;
        wr_en           = 1'b0;
        wr_word.kind    = kind_reg;
        wr_word.key     = key_reg;
        age_ctl.age_all = 1'b0;
        age_ctl.clr     = 1'b0;
        age_ctl.clr_idx = hit_reg ? hit_idx_reg : best_idx_reg;
        out_load        = 1'b0;
        out_last        = 1'b1;
        res             = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready   = 1'b1;
                age_ctl.age_all = in_fire && (in_op == OP_ALLOC)
                                  && (in_kind != KIND_REGVAR);
            end
            ST_BYPASS:
            begin
                out_load      = slot_free;
                res.reg_bank  = 1'b1;
                res.reg_index = sreg_reg;
            end
            ST_SCAN:
            begin
                rd_en = cnt_reg < CNT_W'(NUM_ENTRIES);
            end
            ST_RESOLVE:
            begin
                out_load      = slot_free;
                wr_en         = slot_free && !hit_reg;
                age_ctl.clr   = slot_free;
                res.error     = err_reg;
                res.hit       = hit_reg;
                res.reg_index = REG_INDEX_W'(hit_reg ? hit_idx_reg : best_idx_reg);
                if (!hit_reg)
                begin
                    if (victim_spill)
                    begin
                        res.spill_valid = 1'b1;
                        res.spill_kind  = vic_reg.kind == EK_LOCAL;
                        res.spill_value = VALUE_W'(vic_reg.key);
                    end
                    if (!def_reg)
                    begin
                        res.fill_valid = 1'b1;
                        res.fill_kind  = kind_reg;
                    end
                end
            end
            ST_FL_READ:
            begin
                rd_en = 1'b1;
            end
            ST_FL_PUT:
            begin
                out_load      = slot_free;
                out_last      = cnt_reg == CNT_W'(NUM_ENTRIES - 1);
                res.reg_index = REG_INDEX_W'(cur_idx);
                if (flush_spill)
                begin
                    res.spill_valid = 1'b1;
                    res.spill_kind  = rd_word.kind == EK_LOCAL;
                    res.spill_value = VALUE_W'(rd_word.key);
                end
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            sreg_reg <= s_axis_tdata[VALUE_W+2:VALUE_W];
            def_reg  <= s_axis_tdata[VALUE_W+3];
            if ((in_kind == KIND_IMM) || (in_kind == KIND_GLOBAL)
                || (in_kind == KIND_LOCAL))
            begin
                kind_reg <= in_kind[1:0];
                key_reg  <= KEY_WIDTH'($unsigned(in_key));
                err_reg  <= 1'b0;
            end
            else
            begin
                kind_reg <= EK_IMM;
                key_reg  <= '0;
                err_reg  <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_proc && ((cnt_reg == CNT_W'(1)) || (rd_age > best_age_reg)))
        begin
            best_age_reg <= rd_age;
            best_idx_reg <= scan_idx;
            vic_reg      <= rd_word;
        end
        if (scan_proc && scan_hit && !hit_reg)
        begin
            hit_idx_reg <= scan_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            hit_reg   <= 1'b0;
            valid_reg <= '0;
            dirty_reg <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                cnt_reg <= '0;
                hit_reg <= 1'b0;
            end
            else if (state_reg == ST_SCAN)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (scan_proc && scan_hit)
                begin
                    hit_reg <= 1'b1;
                end
            end
            if ((state_reg == ST_RESOLVE) && slot_free)
            begin
                if (hit_reg)
                begin
                    dirty_reg[hit_idx_reg] <= dirty_reg[hit_idx_reg] | def_reg;
                end
                else
                begin
                    valid_reg[best_idx_reg] <= 1'b1;
                    dirty_reg[best_idx_reg] <= def_reg;
                end
            end
            if ((state_reg == ST_FL_PUT) && slot_free)
            begin
                valid_reg[cur_idx] <= 1'b0;
                dirty_reg[cur_idx] <= 1'b0;
                cnt_reg            <= cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_res_reg  <= res;
            out_last_reg <= out_last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(OUT_TDATA_W - RES_W)'(0), out_res_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule
